// ===== rtl/core/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ffha_pkg: sizes, types, operation codes and tag arithmetic helpers for the
// first-fit heap allocator. Depends on nothing; used by first_fit_heap_allocator.
package ffha_pkg;

   localparam int HEAP_WORDS = 4096;
   localparam int ADDR_W     = $clog2(HEAP_WORDS);
   localparam int WORD_W     = 16;
   localparam int VAL_W      = WORD_W + 2;
   localparam int IDX_W      = ((ADDR_W > 15) ? ADDR_W : 15) + 3;
   localparam int REQ_W      = 15;
   localparam int OFF_W      = 14;
   localparam int CFG_W      = 15;

   localparam int MIN_HEAP_BYTES = 16;
   localparam int MAX_HEAP_BYTES = HEAP_WORDS * 4;

   localparam logic [CFG_W-1:0] HEAP_BYTES_RESET = CFG_W'(16384);

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_CHECK = 2'd3
   } op_type;

   typedef logic signed [IDX_W-1:0] idx_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [WORD_W-1:0]       word_type;
   typedef logic [ADDR_W-1:0]       addr_type;

   localparam val_type END_MARK       = val_type'(1);
   localparam val_type TAG_PAIR_BYTES = val_type'(8);
   localparam val_type INIT_OVERHEAD  = val_type'(12);
   localparam val_type WORD_BYTES     = val_type'(4);
   localparam val_type ROUND_MASK     = val_type'(3);

   function automatic logic idx_ok(idx_type i);
      return (i >= idx_type'(0)) && (i < idx_type'(HEAP_WORDS));
   endfunction

   function automatic val_type mag(val_type v);
      return (v < val_type'(0)) ? val_type'(-v) : v;
   endfunction

   // Word distance (|v| + bias) / 4 used to hop over a block or reach its footer.
   function automatic idx_type step(val_type v, val_type bias);
      return idx_type'((mag(v) + bias) >>> 2);
   endfunction

   function automatic val_type sext(word_type w);
      return val_type'($signed(w));
   endfunction

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// first_fit_heap_allocator: boundary-tag heap manager with first-fit allocation,
// held in one synchronous memory with a registered read port. Depends on ffha_pkg.
//
// Channel  Direction  Handshake            Item
// req      in         req_valid/ready      req_type, request_bytes, block_offset, is_null
// rsp      out        rsp_valid/ready      result_flag, payload_offset
// csr      in         csr_valid/ready      heap_bytes
//
// Init writes the first block's tags and the end mark; free marks the block free and
// merges it with free neighbours; alloc and check walk the headers from the start. The
// header walk over the one memory read port sets the rate. One item is worked on at a
// time; the next is accepted while a finished result still waits in the output register.
// Reset clears control state only; heap contents are undefined until an init item.
module first_fit_heap_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_type,
   input  logic [ffha_pkg::REQ_W-1:0]   req_request_bytes,
   input  logic [ffha_pkg::OFF_W-1:0]   req_block_offset,
   input  logic                         req_is_null,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_result_flag,
   output logic [ffha_pkg::OFF_W-1:0]   rsp_payload_offset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ffha_pkg::CFG_W-1:0]   csr_heap_bytes
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT0,
      S_INIT1,
      S_INIT2,
      S_WALK,
      S_SPLIT0,
      S_SPLIT1,
      S_SPLIT2,
      S_SPLIT3,
      S_FREE_HDR,
      S_FREE_MARK,
      S_FREE_NEXT,
      S_FREE_FOOT,
      S_FREE_PREV,
      S_FREE_PTAG,
      S_FREE_PHDR,
      S_FREE_PFOOT,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   ffha_pkg::op_type             op_ff, op_in;
   ffha_pkg::idx_type            cur_ff, cur_in;
   ffha_pkg::idx_type            h_ff, h_in;
   ffha_pkg::idx_type            prev_ff, prev_in;
   ffha_pkg::idx_type            words_ff, words_in;
   ffha_pkg::val_type            size_ff, size_in;
   ffha_pkg::val_type            tmp_ff, tmp_in;
   ffha_pkg::val_type            hval_ff, hval_in;
   logic                         res_flag_ff, res_flag_in;
   logic [ffha_pkg::OFF_W-1:0]   res_pay_ff, res_pay_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_flag_ff, rsp_flag_in;
   logic [ffha_pkg::OFF_W-1:0]   rsp_pay_ff, rsp_pay_in;
   logic [ffha_pkg::CFG_W-1:0]   heap_bytes_ff, heap_bytes_in;
   logic                         rd_oor_ff, rd_oor_in;

   logic                         rd_req, wr_req;
   ffha_pkg::idx_type            rd_idx, wr_idx;
   ffha_pkg::val_type            wr_val;
   logic                         mem_re, mem_we;
   ffha_pkg::addr_type           mem_raddr, mem_waddr;
   ffha_pkg::word_type           mem_wdata;
   ffha_pkg::word_type           mem_q_ff;
   ffha_pkg::word_type           heap_mem [ffha_pkg::HEAP_WORDS];

   ffha_pkg::val_type            rd_val;
   ffha_pkg::val_type            hb_round;
   ffha_pkg::val_type            init_bytes;
   ffha_pkg::idx_type            split_foot;
   ffha_pkg::idx_type            split_fh;
   ffha_pkg::idx_type            split_rfoot;
   ffha_pkg::idx_type            off_hdr;
   logic                         off_bad;

   assign req_ready          = (state_ff == S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_flag    = rsp_flag_ff;
   assign rsp_payload_offset = rsp_pay_ff;

   // A read beyond the heap returns the end mark.
   assign rd_val = rd_oor_ff ? ffha_pkg::END_MARK : ffha_pkg::sext(mem_q_ff);

   assign hb_round   = ffha_pkg::val_type'({heap_bytes_ff[ffha_pkg::CFG_W-1:2], 2'b00});
   assign init_bytes =
      (hb_round > ffha_pkg::val_type'(ffha_pkg::MAX_HEAP_BYTES)) ?
         ffha_pkg::val_type'(ffha_pkg::MAX_HEAP_BYTES) :
      (hb_round < ffha_pkg::val_type'(ffha_pkg::MIN_HEAP_BYTES)) ?
         ffha_pkg::val_type'(ffha_pkg::MIN_HEAP_BYTES) : hb_round;

   assign split_foot  = cur_ff + ffha_pkg::step(size_ff, ffha_pkg::WORD_BYTES);
   assign split_fh    = split_foot + ffha_pkg::idx_type'(1);
   assign split_rfoot = split_fh + ffha_pkg::step(tmp_ff, ffha_pkg::WORD_BYTES);

   assign off_bad = (req_block_offset[1:0] != 2'b00) ||
                    (req_block_offset[ffha_pkg::OFF_W-1:2] == '0);
   assign off_hdr = ffha_pkg::idx_type'(req_block_offset[ffha_pkg::OFF_W-1:2]) -
                    ffha_pkg::idx_type'(1);

   assign mem_re    = rd_req && ffha_pkg::idx_ok(rd_idx);
   assign mem_raddr = rd_idx[ffha_pkg::ADDR_W-1:0];
   assign mem_we    = wr_req && ffha_pkg::idx_ok(wr_idx);
   assign mem_waddr = wr_idx[ffha_pkg::ADDR_W-1:0];
   assign mem_wdata = wr_val[ffha_pkg::WORD_W-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cur_in        = cur_ff;
      h_in          = h_ff;
      prev_in       = prev_ff;
      words_in      = words_ff;
      size_in       = size_ff;
      tmp_in        = tmp_ff;
      hval_in       = hval_ff;
      res_flag_in   = res_flag_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_flag_in   = rsp_flag_ff;
      rsp_pay_in    = rsp_pay_ff;
      heap_bytes_in = csr_valid ? csr_heap_bytes : heap_bytes_ff;
      rd_req        = 1'b0;
      rd_idx        = '0;
      wr_req        = 1'b0;
      wr_idx        = '0;
      wr_val        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = ffha_pkg::op_type'(req_type);
               res_flag_in = 1'b0;
               res_pay_in  = '0;
               case (ffha_pkg::op_type'(req_type))
                  ffha_pkg::OP_INIT: begin
                     words_in = ffha_pkg::idx_type'(init_bytes >>> 2);
                     tmp_in   = ffha_pkg::val_type'(ffha_pkg::INIT_OVERHEAD - init_bytes);
                     state_in = S_INIT0;
                  end
                  ffha_pkg::OP_ALLOC: begin
                     size_in  = (ffha_pkg::val_type'(req_request_bytes) + ffha_pkg::ROUND_MASK)
                                & ~ffha_pkg::ROUND_MASK;
                     cur_in   = '0;
                     rd_req   = 1'b1;
                     state_in = S_WALK;
                  end
                  ffha_pkg::OP_FREE: begin
                     if (req_is_null) begin
                        res_flag_in = 1'b1;
                        state_in    = S_DONE;
                     end else if (off_bad) begin
                        state_in = S_DONE;
                     end else begin
                        h_in     = off_hdr;
                        rd_req   = 1'b1;
                        rd_idx   = off_hdr;
                        state_in = S_FREE_HDR;
                     end
                  end
                  ffha_pkg::OP_CHECK: begin
                     if (req_is_null || off_bad) begin
                        state_in = S_DONE;
                     end else begin
                        h_in     = off_hdr;
                        cur_in   = '0;
                        rd_req   = 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_INIT0: begin
            wr_req   = 1'b1;
            wr_val   = tmp_ff;
            state_in = S_INIT1;
         end
         S_INIT1: begin
            wr_req   = 1'b1;
            wr_idx   = words_ff - ffha_pkg::idx_type'(2);
            wr_val   = tmp_ff;
            state_in = S_INIT2;
         end
         S_INIT2: begin
            wr_req   = 1'b1;
            wr_idx   = words_ff - ffha_pkg::idx_type'(1);
            wr_val   = ffha_pkg::END_MARK;
            state_in = S_DONE;
         end

         S_WALK: begin
            if (rd_val == ffha_pkg::END_MARK) begin
               state_in = S_DONE;
            end else if ((op_ff == ffha_pkg::OP_ALLOC) && (rd_val < ffha_pkg::val_type'(0)) &&
                         (ffha_pkg::mag(rd_val) > size_ff + ffha_pkg::TAG_PAIR_BYTES)) begin
               tmp_in   = ffha_pkg::val_type'(-rd_val) - size_ff - ffha_pkg::TAG_PAIR_BYTES;
               state_in = S_SPLIT0;
            end else if ((op_ff == ffha_pkg::OP_CHECK) && (rd_val > ffha_pkg::END_MARK) &&
                         (cur_ff == h_ff)) begin
               res_flag_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               cur_in = cur_ff + ffha_pkg::step(rd_val, ffha_pkg::TAG_PAIR_BYTES);
               rd_req = 1'b1;
               rd_idx = cur_ff + ffha_pkg::step(rd_val, ffha_pkg::TAG_PAIR_BYTES);
            end
         end

         S_SPLIT0: begin
            wr_req   = 1'b1;
            wr_idx   = cur_ff;
            wr_val   = size_ff;
            state_in = S_SPLIT1;
         end
         S_SPLIT1: begin
            wr_req   = 1'b1;
            wr_idx   = split_foot;
            wr_val   = size_ff;
            state_in = S_SPLIT2;
         end
         S_SPLIT2: begin
            wr_req   = 1'b1;
            wr_idx   = split_fh;
            wr_val   = ffha_pkg::val_type'(-tmp_ff);
            state_in = S_SPLIT3;
         end
         S_SPLIT3: begin
            wr_req      = 1'b1;
            wr_idx      = split_rfoot;
            wr_val      = ffha_pkg::val_type'(-tmp_ff);
            res_flag_in = 1'b1;
            res_pay_in  = ffha_pkg::OFF_W'({cur_ff[ffha_pkg::OFF_W-3:0], 2'b00} +
                                           ffha_pkg::OFF_W'(4));
            state_in    = S_DONE;
         end

         S_FREE_HDR: begin
            if ((rd_val < ffha_pkg::val_type'(0)) || (rd_val == ffha_pkg::END_MARK)) begin
               state_in = S_DONE;
            end else begin
               size_in  = rd_val;
               state_in = S_FREE_MARK;
            end
         end
         S_FREE_MARK: begin
            wr_req   = 1'b1;
            wr_idx   = h_ff;
            wr_val   = ffha_pkg::val_type'(-size_ff);
            rd_req   = 1'b1;
            rd_idx   = h_ff + ffha_pkg::step(size_ff, ffha_pkg::TAG_PAIR_BYTES);
            state_in = S_FREE_NEXT;
         end
         S_FREE_NEXT: begin
            wr_req = 1'b1;
            if (rd_val < ffha_pkg::val_type'(0)) begin
               tmp_in   = rd_val - size_ff - ffha_pkg::TAG_PAIR_BYTES;
               wr_idx   = h_ff;
               wr_val   = rd_val - size_ff - ffha_pkg::TAG_PAIR_BYTES;
               state_in = S_FREE_FOOT;
            end else begin
               wr_idx   = h_ff + ffha_pkg::step(size_ff, ffha_pkg::WORD_BYTES);
               wr_val   = ffha_pkg::val_type'(-size_ff);
               hval_in  = ffha_pkg::val_type'(-size_ff);
               state_in = S_FREE_PREV;
            end
         end
         S_FREE_FOOT: begin
            wr_req   = 1'b1;
            wr_idx   = h_ff + ffha_pkg::step(tmp_ff, ffha_pkg::WORD_BYTES);
            wr_val   = tmp_ff;
            hval_in  = ffha_pkg::sext(tmp_ff[ffha_pkg::WORD_W-1:0]);
            state_in = S_FREE_PREV;
         end
         S_FREE_PREV: begin
            if (h_ff == ffha_pkg::idx_type'(0)) begin
               state_in = S_DONE;
            end else begin
               rd_req   = 1'b1;
               rd_idx   = h_ff - ffha_pkg::idx_type'(1);
               state_in = S_FREE_PTAG;
            end
         end
         S_FREE_PTAG: begin
            if (rd_val < ffha_pkg::val_type'(0)) begin
               prev_in  = h_ff - ffha_pkg::step(rd_val, ffha_pkg::TAG_PAIR_BYTES);
               rd_req   = 1'b1;
               rd_idx   = h_ff - ffha_pkg::step(rd_val, ffha_pkg::TAG_PAIR_BYTES);
               state_in = S_FREE_PHDR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FREE_PHDR: begin
            tmp_in   = rd_val + hval_ff - ffha_pkg::TAG_PAIR_BYTES;
            wr_req   = 1'b1;
            wr_idx   = prev_ff;
            wr_val   = rd_val + hval_ff - ffha_pkg::TAG_PAIR_BYTES;
            state_in = S_FREE_PFOOT;
         end
         S_FREE_PFOOT: begin
            wr_req   = 1'b1;
            wr_idx   = prev_ff + ffha_pkg::step(tmp_ff, ffha_pkg::WORD_BYTES);
            wr_val   = tmp_ff;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = res_flag_ff;
               rsp_pay_in   = res_pay_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_oor_in = rd_req ? !ffha_pkg::idx_ok(rd_idx) : rd_oor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         heap_bytes_ff <= ffha_pkg::HEAP_BYTES_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         heap_bytes_ff <= heap_bytes_in;
      end
      op_ff       <= op_in;
      cur_ff      <= cur_in;
      h_ff        <= h_in;
      prev_ff     <= prev_in;
      words_ff    <= words_in;
      size_ff     <= size_in;
      tmp_ff      <= tmp_in;
      hval_ff     <= hval_in;
      res_flag_ff <= res_flag_in;
      res_pay_ff  <= res_pay_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_pay_ff  <= rsp_pay_in;
      rd_oor_ff   <= rd_oor_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= heap_mem[mem_raddr];
      end
   end

   a_no_same_entry_rw: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && (mem_waddr == mem_raddr)))
      else $error("heap read and write hit the same entry in one cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the completion state");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("heap written while idle");

endmodule
